// ----- hdl/trd_pkg.sv -----
// ----------------------------------------------------------------------------
// trd_pkg
// Shared constants, format codes and the pixel word type of the TGA RLE
// pixel decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam int CSR_DATA_W = 25;
   localparam int PIXELS_W   = 25;

   localparam logic CSR_PIXEL_FORMAT = 1'b0;
   localparam logic CSR_IMAGE_PIXELS = 1'b1;

   localparam logic [2:0] FMT_INDEXED8 = 3'd0;
   localparam logic [2:0] FMT_RGB555   = 3'd1;
   localparam logic [2:0] FMT_BGR24    = 3'd2;
   localparam logic [2:0] FMT_BGRA32   = 3'd3;
   localparam logic [2:0] FMT_GRAY8    = 3'd4;
   localparam logic [2:0] FMT_GRAYA16  = 3'd5;

   localparam logic [7:0] HDR_REPEAT_BIT = 8'h80;
   localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] count;
      logic       last;
      logic       use_pal;
      logic       pal_oor;
   } pix_type;

   function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
      logic [2:0] bpp;
      case (fmt)
         FMT_INDEXED8: bpp = 3'd1;
         FMT_RGB555:   bpp = 3'd2;
         FMT_BGRA32:   bpp = 3'd4;
         FMT_GRAY8:    bpp = 3'd1;
         FMT_GRAYA16:  bpp = 3'd2;
         default:      bpp = 3'd3;
      endcase
      return bpp;
   endfunction

endpackage

// ----- hdl/trd_req_if.sv -----
// ----------------------------------------------------------------------------
// trd_req_if
// Request channel: stream bytes and palette entry writes.
// ----------------------------------------------------------------------------
interface trd_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  data_byte;
   logic [7:0]  entry_index;
   logic [23:0] entry_color;

   modport source (output valid, cmd, data_byte, entry_index, entry_color,
                   input ready);
   modport sink   (input valid, cmd, data_byte, entry_index, entry_color,
                   output ready);
endinterface

// ----- hdl/trd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// trd_rsp_if
// Response channel: decoded pixels with repeat count and last flag.
// ----------------------------------------------------------------------------
interface trd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [7:0] repeat_res;
   logic       last;

   modport source (output valid, red, green, blue, alpha, repeat_res, last,
                   input ready);
   modport sink   (input valid, red, green, blue, alpha, repeat_res, last,
                   output ready);
endinterface

// ----- hdl/trd_ram.sv -----
// ----------------------------------------------------------------------------
// trd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module trd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/trd_parse.sv -----
// ----------------------------------------------------------------------------
// trd_parse
// Packet parser: config registers, packet and pixel assembly state, run
// clipping against the image total, palette write and read requests.
// ----------------------------------------------------------------------------
module trd_parse #(
   parameter int PALETTE_ENTRIES = trd_pkg::PALETTE_ENTRIES_DEF,
   localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [trd_pkg::CSR_DATA_W-1:0] csr_wr_data,
   trd_req_if.sink                     req_chan,
   input  logic                        space_ok,
   output logic                        pix_valid,
   output trd_pkg::pix_type            pix,
   output logic                        pal_wr_en,
   output logic [ADDR_W-1:0]           pal_wr_addr,
   output logic [23:0]                 pal_wr_data,
   output logic                        pal_rd_en,
   output logic [ADDR_W-1:0]           pal_rd_addr
);
   import trd_pkg::*;

   localparam logic [8:0] ENTRIES_W = 9'(PALETTE_ENTRIES);

   logic [2:0]          pixel_format_ff, pixel_format_in;
   logic [PIXELS_W-1:0] image_pixels_ff, image_pixels_in;

   logic                awaiting_header_ff, awaiting_header_in;
   logic                repeat_packet_ff, repeat_packet_in;
   logic [7:0]          packet_left_ff, packet_left_in;
   logic [1:0]          byte_phase_ff, byte_phase_in;
   logic [23:0]         partial_pixel_ff, partial_pixel_in;
   logic [PIXELS_W-1:0] pixels_done_ff, pixels_done_in;

   logic                accept, stream_acc;
   logic [PIXELS_W-1:0] total, remain;
   logic [2:0]          bpp, phase_next;
   logic [7:0]          b, b0, b1, b2, n, left_new;
   logic [15:0]         c555;

   assign req_chan.ready = space_ok;
   assign accept     = req_chan.valid & space_ok;
   assign stream_acc = accept & ~req_chan.cmd;
   assign b          = req_chan.data_byte;

   assign pal_wr_en   = accept & req_chan.cmd & ({1'b0, req_chan.entry_index} < ENTRIES_W);
   assign pal_wr_addr = req_chan.entry_index[ADDR_W-1:0];
   assign pal_wr_data = req_chan.entry_color;
   assign pal_rd_en   = pix_valid & pix.use_pal;
   assign pal_rd_addr = b[ADDR_W-1:0];

   assign total      = (image_pixels_ff == '0) ? PIXELS_W'(1) : image_pixels_ff;
   assign remain     = total - pixels_done_ff;
   assign bpp        = bytes_per_pixel(pixel_format_ff);
   assign phase_next = {1'b0, byte_phase_ff} + 3'd1;
   assign b0         = partial_pixel_ff[7:0];
   assign b1         = partial_pixel_ff[15:8];
   assign b2         = partial_pixel_ff[23:16];
   assign c555       = {b, b0};

   always_comb begin
      pixel_format_in = pixel_format_ff;
      image_pixels_in = image_pixels_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_in = csr_wr_data[2:0];
            CSR_IMAGE_PIXELS: image_pixels_in = csr_wr_data[PIXELS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      awaiting_header_in = awaiting_header_ff;
      repeat_packet_in   = repeat_packet_ff;
      packet_left_in     = packet_left_ff;
      byte_phase_in      = byte_phase_ff;
      partial_pixel_in   = partial_pixel_ff;
      pixels_done_in     = pixels_done_ff;
      pix_valid          = 1'b0;
      pix                = '0;
      n                  = 8'd0;
      left_new           = packet_left_ff;
      if (stream_acc) begin
         if (awaiting_header_ff) begin
            repeat_packet_in   = |(b & HDR_REPEAT_BIT);
            packet_left_in     = (b & HDR_COUNT_MASK) + 8'd1;
            byte_phase_in      = 2'd0;
            partial_pixel_in   = 24'd0;
            awaiting_header_in = 1'b0;
            if (pixels_done_ff >= total) begin
               pixels_done_in = '0;
            end
         end else if (phase_next < bpp) begin
            case (byte_phase_ff)
               2'd0:    partial_pixel_in = partial_pixel_ff | {16'd0, b};
               2'd1:    partial_pixel_in = partial_pixel_ff | {8'd0, b, 8'd0};
               2'd2:    partial_pixel_in = partial_pixel_ff | {b, 16'd0};
               default: partial_pixel_in = partial_pixel_ff;
            endcase
            byte_phase_in = byte_phase_ff + 2'd1;
         end else begin
            case (pixel_format_ff)
               FMT_INDEXED8: begin
                  pix.use_pal = 1'b1;
                  pix.pal_oor = ({1'b0, b} >= ENTRIES_W);
               end
               FMT_RGB555: begin
                  pix.red   = {c555[14:10], 3'd0};
                  pix.green = {c555[9:5], 3'd0};
                  pix.blue  = {c555[4:0], 3'd0};
               end
               FMT_BGRA32: begin
                  pix.blue  = b0;
                  pix.green = b1;
                  pix.red   = b2;
                  pix.alpha = b;
               end
               FMT_GRAY8: begin
                  pix.red = b;
               end
               FMT_GRAYA16: begin
                  pix.red   = b0;
                  pix.alpha = b;
               end
               default: begin
                  pix.blue  = b0;
                  pix.green = b1;
                  pix.red   = b;
               end
            endcase
            byte_phase_in    = 2'd0;
            partial_pixel_in = 24'd0;
            if (repeat_packet_ff) begin
               n        = packet_left_ff;
               left_new = 8'd0;
            end else begin
               n        = 8'd1;
               left_new = (packet_left_ff != 8'd0) ? packet_left_ff - 8'd1 : 8'd0;
            end
            packet_left_in = left_new;
            if (left_new == 8'd0) begin
               awaiting_header_in = 1'b1;
            end
            if (n != 8'd0 && pixels_done_ff < total) begin
               pix_valid = 1'b1;
               if (PIXELS_W'(n) >= remain) begin
                  pix.count      = remain[7:0];
                  pix.last       = 1'b1;
                  pixels_done_in = total;
               end else begin
                  pix.count      = n;
                  pix.last       = 1'b0;
                  pixels_done_in = pixels_done_ff + PIXELS_W'(n);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff    <= FMT_BGR24;
         image_pixels_ff    <= PIXELS_W'(1);
         awaiting_header_ff <= 1'b1;
         repeat_packet_ff   <= 1'b0;
         packet_left_ff     <= 8'd0;
         byte_phase_ff      <= 2'd0;
         partial_pixel_ff   <= 24'd0;
         pixels_done_ff     <= '0;
      end else begin
         pixel_format_ff    <= pixel_format_in;
         image_pixels_ff    <= image_pixels_in;
         awaiting_header_ff <= awaiting_header_in;
         repeat_packet_ff   <= repeat_packet_in;
         packet_left_ff     <= packet_left_in;
         byte_phase_ff      <= byte_phase_in;
         partial_pixel_ff   <= partial_pixel_in;
         pixels_done_ff     <= pixels_done_in;
      end
   end

`ifndef SYNTHESIS
   a_hdr_taken: assert property (@(posedge clock) disable iff (reset)
      stream_acc && awaiting_header_ff |=> !awaiting_header_ff)
      else $error("header byte did not open a packet");

   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      !awaiting_header_ff |-> packet_left_ff != 8'd0)
      else $error("open packet with no pixels left");

   a_literal_count: assert property (@(posedge clock) disable iff (reset)
      pix_valid && !repeat_packet_ff |-> pix.count == 8'd1)
      else $error("literal pixel with count other than one");
`endif

endmodule

// ----- hdl/trd_out.sv -----
// ----------------------------------------------------------------------------
// trd_out
// Result register: holds one decoded pixel, merges palette read data for
// indexed pixels and drives the response channel.
// ----------------------------------------------------------------------------
module trd_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             pix_valid,
   input  trd_pkg::pix_type pix,
   input  logic [23:0]      pal_rd_data,
   output logic             space_ok,
   trd_rsp_if.source        rsp_chan
);
   import trd_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   pix_type s1_ff;

   assign space_ok = ~s1_valid_ff | rsp_chan.ready;

   always_comb begin
      if (pix_valid) begin
         s1_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_valid) begin
         s1_ff <= pix;
      end
   end

   always_comb begin
      rsp_chan.valid      = s1_valid_ff;
      rsp_chan.alpha      = s1_ff.alpha;
      rsp_chan.repeat_res = s1_ff.count;
      rsp_chan.last       = s1_ff.last;
      if (s1_ff.use_pal) begin
         if (s1_ff.pal_oor) begin
            rsp_chan.red   = 8'd0;
            rsp_chan.green = 8'd0;
            rsp_chan.blue  = 8'd0;
         end else begin
            rsp_chan.red   = pal_rd_data[23:16];
            rsp_chan.green = pal_rd_data[15:8];
            rsp_chan.blue  = pal_rd_data[7:0];
         end
      end else begin
         rsp_chan.red   = s1_ff.red;
         rsp_chan.green = s1_ff.green;
         rsp_chan.blue  = s1_ff.blue;
      end
   end

`ifndef SYNTHESIS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      pix_valid |-> space_ok)
      else $error("pixel produced while result register full");

   a_pal_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.use_pal && !rsp_chan.ready |=> $stable(pal_rd_data))
      else $error("palette data changed under a stalled result");
`endif

endmodule

// ----- hdl/tga_rle_pixel_decoder_core.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// TGA run-length pixel decoder, one compressed byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// req_chan carries one word per cycle: a stream byte (cmd 0) or a palette
// entry write (cmd 1). rsp_chan carries decoded pixels: color, alpha, the
// repeat count of a run packet and a last flag when the image total is hit.
// csr_* writes pixel_format (index 0) and image_pixels (index 1); the user
// must write them only while the block is idle, which it does not enforce.
// Throughput is one request word per cycle while req_chan.ready is high.
// The palette lives in a RAM with a registered read; an indexed lookup
// issues its read in the cycle the final pixel byte is taken.
// Latency: a result is valid on rsp_chan the cycle after the byte that
// completes it is accepted. Header and partial pixel bytes give no result.
// A single result register sits between the channels: while it is full and
// rsp_chan.ready is low, req_chan.ready is low.
// Reset (synchronous) restores pixel_format to bgr24, image_pixels to 1 and
// the parser to expect a packet header. Palette contents are not cleared
// and are undefined until written.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_core #(
   parameter int PALETTE_ENTRIES = trd_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [trd_pkg::CSR_DATA_W-1:0] csr_wr_data,
   trd_req_if.sink                        req_chan,
   trd_rsp_if.source                      rsp_chan
);
   import trd_pkg::*;

   localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic              space_ok;
   logic              pix_valid;
   pix_type           pix;
   logic              pal_wr_en;
   logic [ADDR_W-1:0] pal_wr_addr;
   logic [23:0]       pal_wr_data;
   logic              pal_rd_en;
   logic [ADDR_W-1:0] pal_rd_addr;
   logic [23:0]       pal_rd_data;

   trd_parse #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .space_ok    (space_ok),
      .pix_valid   (pix_valid),
      .pix         (pix),
      .pal_wr_en   (pal_wr_en),
      .pal_wr_addr (pal_wr_addr),
      .pal_wr_data (pal_wr_data),
      .pal_rd_en   (pal_rd_en),
      .pal_rd_addr (pal_rd_addr)
   );

   trd_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (pal_wr_data),
      .rd_en   (pal_rd_en),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   trd_out u_out (
      .clock       (clock),
      .reset       (reset),
      .pix_valid   (pix_valid),
      .pix         (pix),
      .pal_rd_data (pal_rd_data),
      .space_ok    (space_ok),
      .rsp_chan    (rsp_chan)
   );

endmodule
